FILE: sv/rtme_pkg.sv
// shared types and constants for the register machine execute block
package rtme_pkg;

   localparam int WORD_W    = 32;
   localparam int ADDR_W    = 16;
   localparam int REG_N     = 16;
   localparam int REG_AW    = $clog2(REG_N);
   localparam int MEM_DEPTH = 256;
   localparam int MEM_AW    = $clog2(MEM_DEPTH);

   localparam logic [REG_AW-1:0] SP_REG    = REG_AW'(14);
   localparam logic [REG_AW-1:0] FLAGS_REG = REG_AW'(15);
   localparam logic [WORD_W-1:0] SP_RESET  = WORD_W'(32'hff) + WORD_W'(1);
   localparam logic [WORD_W-1:0] SP_STEP   = WORD_W'(2);

   typedef enum logic [3:0] {
      FN_MOV   = 4'd0,
      FN_ADD   = 4'd1,
      FN_SUB   = 4'd2,
      FN_CMP   = 4'd3,
      FN_JMP   = 4'd4,
      FN_JE    = 4'd5,
      FN_JNE   = 4'd6,
      FN_PUSH  = 4'd7,
      FN_POP   = 4'd8,
      FN_CALL  = 4'd9,
      FN_RET   = 4'd10,
      FN_OUT   = 4'd11,
      FN_IN    = 4'd12,
      FN_STORE = 4'd13,
      FN_LOAD  = 4'd14,
      FN_EXIT  = 4'd15
   } func_type;

   typedef struct packed {
      func_type            func;
      logic [REG_AW-1:0]   dst;
      logic [REG_AW-1:0]   src_a;
      logic [REG_AW-1:0]   src_b;
      logic                use_imm;
      logic                use_base;
      logic [WORD_W-1:0]   imm;
      logic [ADDR_W-1:0]   target;
      logic [ADDR_W-1:0]   ret_addr;
      logic [WORD_W-1:0]   in_value;
   } item_type;

   // second stage: result fields plus the register updates of one item
   typedef struct packed {
      logic                out_valid;
      logic [WORD_W-1:0]   out_value;
      logic                jump_taken;
      logic [ADDR_W-1:0]   jump_addr;
      logic                halt;
      logic                is_ret;
      logic                ld;
      logic                is_pop;
      logic [REG_AW-1:0]   dst;
      logic                rf_we;
      logic [WORD_W-1:0]   rf_data;
      logic                sp_we;
      logic [WORD_W-1:0]   sp_data;
      logic                fl_we;
      logic [WORD_W-1:0]   fl_data;
   } stage_type;

   typedef struct packed {
      logic                we;
      logic                re;
      logic [MEM_AW-1:0]   addr;
      logic [WORD_W-1:0]   wdata;
   } mem_req_type;

endpackage

FILE: sv/toy_register_machine_execute.sv
// top level of the register machine execute block
//
// one decoded instruction enters on the req_ channel per item; every item
// gives exactly one result item on the rsp_ channel (out value, jump
// redirect, halt). both channels use valid/stall handshakes.
// pipeline: input register with register file read, execute in stage one
// with stack memory access, writeback stage, then the result register.
// a result passes the input register, writeback stage and result register.
// throughput: one item per cycle while rsp_stall is low; an item that follows
// a pop or load into one of its source registers, the stack pointer or the
// flags waits in stage one until that load leaves the writeback stage.
// register file and stack memory are single write port rams.
// after reset a clearing sweep over all MEM_DEPTH (256) addresses zeroes both rams
// with req_stall held high; the stack pointer resets to 256.
// when rsp_stall is high the result register holds and the pipeline fills,
// then req_stall rises; up to three items wait inside the block.
module toy_register_machine_execute (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [3:0]                           req_func,
   input  logic [rtme_pkg::REG_AW-1:0]          req_dst_reg,
   input  logic [rtme_pkg::REG_AW-1:0]          req_src_a_reg,
   input  logic [rtme_pkg::REG_AW-1:0]          req_src_b_reg,
   input  logic                                 req_use_imm,
   input  logic                                 req_use_base,
   input  logic signed [rtme_pkg::WORD_W-1:0]   req_immediate,
   input  logic [rtme_pkg::ADDR_W-1:0]          req_target_addr,
   input  logic [rtme_pkg::ADDR_W-1:0]          req_return_addr,
   input  logic signed [rtme_pkg::WORD_W-1:0]   req_in_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_out_valid,
   output logic signed [rtme_pkg::WORD_W-1:0]   rsp_out_value,
   output logic                                 rsp_jump_taken,
   output logic [rtme_pkg::ADDR_W-1:0]          rsp_jump_addr,
   output logic                                 rsp_halt
);
   import rtme_pkg::*;

   // clearing sweep
   logic              clr_busy_ff, clr_busy_in;
   logic [MEM_AW-1:0] clr_idx_ff, clr_idx_in;
   logic              clr_rf;

   // pipeline control
   logic      req_acc;
   logic      s1_valid_ff, s1_valid_in;
   item_type  s1_item_ff, s1_item_in;
   logic      s2_valid_ff, s2_valid_in;
   stage_type s2_ff;
   stage_type s1_stage;
   mem_req_type s1_mem;
   logic      hazard;
   logic      s1_go;
   logic      s2_go;
   logic      s2_free;
   logic      out_ready;

   // architectural flops
   logic [WORD_W-1:0] sp_ff, sp_in;
   logic [WORD_W-1:0] fl_ff, fl_in;
   logic [WORD_W-1:0] sp_cur;
   logic [WORD_W-1:0] fl_cur;

   // register file rams and forwarding
   logic [REG_AW-1:0] rf_rd_a, rf_rd_b;
   logic [WORD_W-1:0] rf_q_a, rf_q_b;
   logic              rf_wr_en;
   logic [REG_AW-1:0] rf_wr_addr;
   logic [WORD_W-1:0] rf_wr_data;
   logic              last_we_ff;
   logic [REG_AW-1:0] last_addr_ff;
   logic [WORD_W-1:0] last_data_ff;
   logic [WORD_W-1:0] ra, rb;

   // stack memory
   logic              mem_wr_en;
   logic [MEM_AW-1:0] mem_wr_addr;
   logic [WORD_W-1:0] mem_wr_data;
   logic [WORD_W-1:0] mem_q;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              o_valid_ff;
   logic [WORD_W-1:0] o_value_ff;
   logic              o_jump_ff;
   logic [ADDR_W-1:0] o_jaddr_ff;
   logic              o_halt_ff;

   // handshake and flow
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s2_go     = s2_valid_ff && out_ready;
   assign s2_free   = !s2_valid_ff || out_ready;
   assign hazard    = s2_valid_ff && s2_ff.ld &&
                      (s2_ff.dst == s1_item_ff.src_a || s2_ff.dst == s1_item_ff.src_b ||
                       s2_ff.dst == SP_REG || s2_ff.dst == FLAGS_REG);
   assign s1_go     = s1_valid_ff && !hazard && s2_free;
   assign req_stall = clr_busy_ff || (s1_valid_ff && !s1_go);
   assign req_acc   = req_valid && !req_stall;

   assign s1_valid_in = req_acc || (s1_valid_ff && !s1_go);
   assign s2_valid_in = s1_go || (s2_valid_ff && !s2_go);

   always_comb begin
      s1_item_in = s1_item_ff;
      if (req_acc) begin
         s1_item_in.func     = func_type'(req_func);
         s1_item_in.dst      = req_dst_reg;
         s1_item_in.src_a    = req_src_a_reg;
         s1_item_in.src_b    = req_src_b_reg;
         s1_item_in.use_imm  = req_use_imm;
         s1_item_in.use_base = req_use_base;
         s1_item_in.imm      = $unsigned(req_immediate);
         s1_item_in.target   = req_target_addr;
         s1_item_in.ret_addr = req_return_addr;
         s1_item_in.in_value = $unsigned(req_in_value);
      end
   end

   // clearing sweep
   assign clr_rf      = clr_busy_ff && ({1'b0, clr_idx_ff} < (MEM_AW + 1)'(REG_N));
   assign clr_idx_in  = clr_busy_ff ? clr_idx_ff + MEM_AW'(1) : clr_idx_ff;
   assign clr_busy_in = clr_busy_ff && (clr_idx_ff != MEM_AW'(MEM_DEPTH - 1));

   // register reads, re-issued every cycle while an item waits in stage one
   assign rf_rd_a = req_acc ? req_src_a_reg : s1_item_ff.src_a;
   assign rf_rd_b = req_acc ? req_src_b_reg : s1_item_ff.src_b;

   assign sp_cur = (s2_valid_ff && s2_ff.sp_we) ? s2_ff.sp_data : sp_ff;
   assign fl_cur = (s2_valid_ff && s2_ff.fl_we) ? s2_ff.fl_data : fl_ff;

   always_comb begin
      if (s1_item_ff.src_a == SP_REG) begin
         ra = sp_cur;
      end else if (s1_item_ff.src_a == FLAGS_REG) begin
         ra = fl_cur;
      end else if (s2_valid_ff && s2_ff.rf_we && s2_ff.dst == s1_item_ff.src_a) begin
         ra = s2_ff.rf_data;
      end else if (last_we_ff && last_addr_ff == s1_item_ff.src_a) begin
         ra = last_data_ff;
      end else begin
         ra = rf_q_a;
      end
      if (s1_item_ff.src_b == SP_REG) begin
         rb = sp_cur;
      end else if (s1_item_ff.src_b == FLAGS_REG) begin
         rb = fl_cur;
      end else if (s2_valid_ff && s2_ff.rf_we && s2_ff.dst == s1_item_ff.src_b) begin
         rb = s2_ff.rf_data;
      end else if (last_we_ff && last_addr_ff == s1_item_ff.src_b) begin
         rb = last_data_ff;
      end else begin
         rb = rf_q_b;
      end
   end

   rtme_exec u_exec (
      .item    (s1_item_ff),
      .ra      (ra),
      .rb      (rb),
      .sp      (sp_cur),
      .flags   (fl_cur),
      .stage   (s1_stage),
      .mem_req (s1_mem)
   );

   // writeback
   always_comb begin
      rf_wr_en   = 1'b0;
      rf_wr_addr = s2_ff.dst;
      rf_wr_data = s2_ff.ld ? mem_q : s2_ff.rf_data;
      sp_in      = sp_ff;
      fl_in      = fl_ff;
      if (clr_busy_ff) begin
         rf_wr_en   = clr_rf;
         rf_wr_addr = clr_idx_ff[REG_AW-1:0];
         rf_wr_data = '0;
      end else if (s2_go) begin
         rf_wr_en = s2_ff.rf_we ||
                    (s2_ff.ld && s2_ff.dst != SP_REG && s2_ff.dst != FLAGS_REG);
         if (s2_ff.ld && s2_ff.dst == SP_REG) begin
            sp_in = s2_ff.is_pop ? mem_q + SP_STEP : mem_q;
         end else if (s2_ff.sp_we) begin
            sp_in = s2_ff.sp_data;
         end
         if (s2_ff.ld && s2_ff.dst == FLAGS_REG) begin
            fl_in = mem_q;
         end else if (s2_ff.fl_we) begin
            fl_in = s2_ff.fl_data;
         end
      end
   end

   rtme_ram #(.WIDTH(WORD_W), .DEPTH(REG_N)) u_rf_a (
      .clock   (clock),
      .wr_en   (rf_wr_en),
      .wr_addr (rf_wr_addr),
      .wr_data (rf_wr_data),
      .rd_en   (1'b1),
      .rd_addr (rf_rd_a),
      .rd_data (rf_q_a)
   );

   rtme_ram #(.WIDTH(WORD_W), .DEPTH(REG_N)) u_rf_b (
      .clock   (clock),
      .wr_en   (rf_wr_en),
      .wr_addr (rf_wr_addr),
      .wr_data (rf_wr_data),
      .rd_en   (1'b1),
      .rd_addr (rf_rd_b),
      .rd_data (rf_q_b)
   );

   // stack memory
   assign mem_wr_en   = clr_busy_ff || (s1_go && s1_mem.we);
   assign mem_wr_addr = clr_busy_ff ? clr_idx_ff : s1_mem.addr;
   assign mem_wr_data = clr_busy_ff ? '0 : s1_mem.wdata;

   rtme_ram #(.WIDTH(WORD_W), .DEPTH(MEM_DEPTH)) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (s1_go && s1_mem.re),
      .rd_addr (s1_mem.addr),
      .rd_data (mem_q)
   );

   assign rsp_valid_in = s2_go || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_idx_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         last_we_ff   <= 1'b0;
         sp_ff        <= SP_RESET;
         fl_ff        <= '0;
      end else begin
         clr_busy_ff  <= clr_busy_in;
         clr_idx_ff   <= clr_idx_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         last_we_ff   <= rf_wr_en;
         sp_ff        <= sp_in;
         fl_ff        <= fl_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff   <= s1_item_in;
      last_addr_ff <= rf_wr_addr;
      last_data_ff <= rf_wr_data;
      if (s1_go) begin
         s2_ff <= s1_stage;
      end
      if (s2_go) begin
         o_valid_ff <= s2_ff.out_valid;
         o_value_ff <= s2_ff.out_value;
         o_jump_ff  <= s2_ff.jump_taken;
         o_jaddr_ff <= s2_ff.is_ret ? mem_q[ADDR_W-1:0] : s2_ff.jump_addr;
         o_halt_ff  <= s2_ff.halt;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_valid  = o_valid_ff;
   assign rsp_out_value  = $signed(o_value_ff);
   assign rsp_jump_taken = o_jump_ff;
   assign rsp_jump_addr  = o_jaddr_ff;
   assign rsp_halt       = o_halt_ff;

`ifndef ASSERT_OFF
   a_no_item_in_sweep: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !s1_valid_ff && !s2_valid_ff)
      else $error("item in pipeline during clearing sweep");

   a_hazard_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && hazard) |=> s1_valid_ff && $stable(s1_item_ff))
      else $error("interlocked item left stage one");

   a_no_load_forward: assert property (@(posedge clock) disable iff (reset)
      (s1_go && s2_valid_ff && s2_ff.ld) |->
      (s2_ff.dst != s1_item_ff.src_a && s2_ff.dst != s1_item_ff.src_b))
      else $error("item advanced past a pending load of its source");

   a_ret_redirects: assert property (@(posedge clock) disable iff (reset)
      (s2_go && s2_ff.is_ret) |=> rsp_valid && rsp_jump_taken)
      else $error("return did not redirect");
`endif

endmodule

FILE: sv/rtme_ram.sv
// generic single write port ram with registered read
module rtme_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/rtme_exec.sv
// instruction decode and execute for the first pipeline stage
module rtme_exec (
   input  rtme_pkg::item_type          item,
   input  logic [rtme_pkg::WORD_W-1:0] ra,
   input  logic [rtme_pkg::WORD_W-1:0] rb,
   input  logic [rtme_pkg::WORD_W-1:0] sp,
   input  logic [rtme_pkg::WORD_W-1:0] flags,
   output rtme_pkg::stage_type         stage,
   output rtme_pkg::mem_req_type       mem_req
);
   import rtme_pkg::*;

   logic [WORD_W-1:0] opnd;
   logic [WORD_W-1:0] addr;
   logic [WORD_W-1:0] spm2;
   logic [WORD_W-1:0] spp2;
   logic [WORD_W-1:0] wval;
   logic              wen;

   assign opnd = item.use_imm ? item.imm : rb;
   assign addr = (item.use_base ? ra : '0) + (item.use_imm ? item.imm : '0);
   assign spm2 = sp - SP_STEP;
   assign spp2 = sp + SP_STEP;

   always_comb begin
      stage   = '0;
      mem_req = '0;
      wen     = 1'b0;
      wval    = '0;
      stage.dst = item.dst;
      unique case (item.func)
         FN_MOV: begin
            wen  = 1'b1;
            wval = item.use_imm ? item.imm : ra;
         end
         FN_ADD: begin
            wen  = 1'b1;
            wval = ra + opnd;
         end
         FN_SUB: begin
            wen  = 1'b1;
            wval = ra - opnd;
         end
         FN_CMP: begin
            stage.fl_we   = 1'b1;
            stage.fl_data = WORD_W'(ra == opnd);
         end
         FN_JMP: begin
            stage.jump_taken = 1'b1;
            stage.jump_addr  = item.target;
         end
         FN_JE: begin
            stage.jump_taken = (flags != '0);
            stage.jump_addr  = (flags != '0) ? item.target : '0;
         end
         FN_JNE: begin
            stage.jump_taken = (flags == '0);
            stage.jump_addr  = (flags == '0) ? item.target : '0;
         end
         FN_PUSH: begin
            stage.sp_we   = 1'b1;
            stage.sp_data = spm2;
            mem_req.we    = 1'b1;
            mem_req.addr  = spm2[MEM_AW-1:0];
            // pushing the stack pointer stores its decremented value
            mem_req.wdata = item.use_imm ? item.imm :
                            ((item.src_a == SP_REG) ? spm2 : ra);
         end
         FN_POP: begin
            stage.sp_we   = 1'b1;
            stage.sp_data = spp2;
            stage.ld      = 1'b1;
            stage.is_pop  = 1'b1;
            mem_req.re    = 1'b1;
            mem_req.addr  = sp[MEM_AW-1:0];
         end
         FN_CALL: begin
            stage.sp_we      = 1'b1;
            stage.sp_data    = spm2;
            stage.jump_taken = 1'b1;
            stage.jump_addr  = item.target;
            mem_req.we       = 1'b1;
            mem_req.addr     = spm2[MEM_AW-1:0];
            mem_req.wdata    = WORD_W'(item.ret_addr);
         end
         FN_RET: begin
            stage.sp_we      = 1'b1;
            stage.sp_data    = spp2;
            stage.jump_taken = 1'b1;
            stage.is_ret     = 1'b1;
            mem_req.re       = 1'b1;
            mem_req.addr     = sp[MEM_AW-1:0];
         end
         FN_OUT: begin
            stage.out_valid = 1'b1;
            stage.out_value = item.use_imm ? item.imm : ra;
         end
         FN_IN: begin
            wen  = 1'b1;
            wval = item.in_value;
         end
         FN_STORE: begin
            mem_req.we    = 1'b1;
            mem_req.addr  = addr[MEM_AW-1:0];
            mem_req.wdata = rb;
         end
         FN_LOAD: begin
            stage.ld     = 1'b1;
            mem_req.re   = 1'b1;
            mem_req.addr = addr[MEM_AW-1:0];
         end
         FN_EXIT: begin
            stage.halt = 1'b1;
         end
      endcase

      // stack pointer and flags live in flops, the rest in the ram
      if (wen) begin
         if (item.dst == SP_REG) begin
            stage.sp_we   = 1'b1;
            stage.sp_data = wval;
         end else if (item.dst == FLAGS_REG) begin
            stage.fl_we   = 1'b1;
            stage.fl_data = wval;
         end else begin
            stage.rf_we   = 1'b1;
            stage.rf_data = wval;
         end
      end
   end

endmodule
